// ----- design/pls_pkg.sv -----
// ---------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list engine.
// ---------------------------------------------------------------------------
package pls_pkg;

  localparam int unsigned IDX_W = 9;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } pls_op_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  position;
    logic [31:0] data_in;
  } pls_in_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic        hit;
    logic        full_res;
    logic [4:0]  count;
  } pls_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] cnt;
  } pls_ctrl_t;

endpackage

// ----- design/positional_list_engine.sv -----
// ---------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY words with append, insert, remove and read
// by position, built as a row of shifting cells.
// ---------------------------------------------------------------------------
// Each transfer is finished at the accepting edge: every cell loads its new
// word or its neighbor's word at the same edge, and the result is registered
// at that edge, so one item is taken per cycle while the result side keeps
// up; the result appears on the cycle after the input transfer. The read path
// is a select across all cells, and it sets the clock for large CAPACITY. The
// store needs no clearing after reset: only entries below the count are read.
module positional_list_engine #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pls_pkg::pls_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pls_pkg::pls_out_t out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_valid_r;
  pls_pkg::pls_out_t      out_data_r;
  pls_pkg::pls_out_t      out_data_nxt;
  pls_pkg::pls_ctrl_t     ctrl;
  logic                   accept;
  logic                   is_ins;
  logic                   is_full;
  logic                   pos_ok;
  logic [pls_pkg::IDX_W-1:0] pos9;
  logic [pls_pkg::IDX_W-1:0] cnt9;
  logic [63:0]            in_ext;
  logic [63:0]            rd_ext;
  logic [DATA_WIDTH-1:0]  wr_word;
  logic [DATA_WIDTH-1:0]  rd_word;
  logic [DATA_WIDTH-1:0]  words    [CAPACITY];
  logic [DATA_WIDTH-1:0]  rd_words [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_ins  = (in_data.func == pls_pkg::OP_APPEND) || (in_data.func == pls_pkg::OP_INSERT);
  assign is_full = (count_r == CAP);
  assign pos9    = pls_pkg::IDX_W'(in_data.position);
  assign cnt9    = pls_pkg::IDX_W'(count_r);
  assign pos_ok  = pos9 < cnt9;
  assign in_ext  = 64'(in_data.data_in);
  assign wr_word = in_ext[DATA_WIDTH-1:0];

  always_comb begin
    ctrl.ins_en = accept && is_ins && !is_full;
    ctrl.rem_en = accept && (in_data.func == pls_pkg::OP_REMOVE) && pos_ok;
    ctrl.cnt    = cnt9;
    ctrl.pos    = pos9;
    if (in_data.func == pls_pkg::OP_APPEND ||
        (in_data.func == pls_pkg::OP_INSERT && !pos_ok)) begin
      ctrl.pos = cnt9;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w;
    logic [DATA_WIDTH-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_body
      assign next_w = words[i+1];
    end
    pls_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .INDEX     (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .wr_word  (wr_word),
      .prev_word(prev_w),
      .next_word(next_w),
      .word     (words[i]),
      .rd_word  (rd_words[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | rd_words[i];
    end
  end

  assign rd_ext = 64'(rd_word);

  always_comb begin
    count_nxt              = count_r;
    out_data_nxt.data_out  = '0;
    out_data_nxt.hit       = 1'b0;
    out_data_nxt.full_res  = 1'b0;
    if (is_ins) begin
      if (is_full) begin
        out_data_nxt.full_res = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else if (pos_ok) begin
      out_data_nxt.hit      = 1'b1;
      out_data_nxt.data_out = rd_ext[31:0];
      if (in_data.func == pls_pkg::OP_REMOVE) begin
        count_nxt = count_r - 1'b1;
      end
    end
    out_data_nxt.count = 5'(pls_pkg::IDX_W'(count_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/pls_cell.sv -----
// ---------------------------------------------------------------------------
// pls_cell
// One list entry: loads the new word, takes a neighbor's word on a shift,
// and drives its word to the read bus when selected.
// ---------------------------------------------------------------------------
module pls_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk,
  input  pls_pkg::pls_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0] wr_word,
  input  logic [DATA_WIDTH-1:0] prev_word,
  input  logic [DATA_WIDTH-1:0] next_word,
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] rd_word
);

  localparam logic [pls_pkg::IDX_W-1:0] IDX = pls_pkg::IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.ins_en) begin
      if (IDX == ctrl.pos) begin
        word_nxt = wr_word;
      end else if (IDX > ctrl.pos && IDX <= ctrl.cnt) begin
        word_nxt = prev_word;
      end
    end else if (ctrl.rem_en) begin
      if (IDX >= ctrl.pos && (IDX + 1'b1) < ctrl.cnt) begin
        word_nxt = next_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign rd_word = (IDX == ctrl.pos) ? word_r : '0;

endmodule

// ----- design/pls_checker.sv -----
// ---------------------------------------------------------------------------
// pls_checker
// Port-level checks for the positional list engine, bound to the top level.
// ---------------------------------------------------------------------------
module pls_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input pls_pkg::pls_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a transfer in always yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("result missing after input transfer");

  a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.full_res))
    else $error("hit and full together");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.data_out == 32'd0)
    else $error("data on a miss");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 31) || (32'(out_data.count) <= CAPACITY))
    else $error("count beyond capacity");

endmodule

bind positional_list_engine pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ----- sim/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Testbench for positional_list_engine. A scoreboard class keeps its own
// copy of the list and predicts each result from every input transfer.
// Directed items cover the empty, full and out-of-range cases. Random phases
// then push the list toward full, toward empty, or hold it balanced. Both
// sides idle at random, the receiver holds off for a long stretch once, and
// the sender waits for every result after each phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 305;

  localparam int BIAS_FILL     = 0;
  localparam int BIAS_DRAIN    = 1;
  localparam int BIAS_BALANCED = 2;

  class list_scoreboard;
    logic [31:0]       words [DEPTH];
    int unsigned       held;
    pls_pkg::pls_out_t expected_q [$];
    int unsigned       mismatches;

    function new();
      held       = 0;
      mismatches = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void note_input(pls_pkg::pls_in_t it);
      pls_pkg::pls_out_t exp_res;
      int unsigned k;
      exp_res = '0;
      case (pls_pkg::pls_op_t'(it.func))
        pls_pkg::OP_APPEND, pls_pkg::OP_INSERT: begin
          if (held >= DEPTH) begin
            exp_res.full_res = 1'b1;
          end else begin
            if (pls_pkg::pls_op_t'(it.func) == pls_pkg::OP_INSERT && it.position < held) begin
              for (k = held; k > it.position; k--) words[k] = words[k - 1];
              words[it.position] = it.data_in;
            end else begin
              words[held] = it.data_in;
            end
            held++;
          end
        end
        default: begin
          if (it.position < held) begin
            exp_res.data_out = words[it.position];
            exp_res.hit      = 1'b1;
            if (pls_pkg::pls_op_t'(it.func) == pls_pkg::OP_REMOVE) begin
              for (k = it.position; k + 1 < held; k++) words[k] = words[k + 1];
              held--;
            end
          end
        end
      endcase
      exp_res.count = held[4:0];
      expected_q.push_back(exp_res);
    endfunction

    function void check_result(pls_pkg::pls_out_t got);
      pls_pkg::pls_out_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transfer: data_out=%h hit=%b full_res=%b count=%0d",
                   got.data_out, got.hit, got.full_res, got.count);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.data_out !== exp_res.data_out || got.hit !== exp_res.hit ||
          got.full_res !== exp_res.full_res || got.count !== exp_res.count) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"mismatch: expected data_out=%h hit=%b full_res=%b count=%0d,",
                    " got data_out=%h hit=%b full_res=%b count=%0d"},
                   exp_res.data_out, exp_res.hit, exp_res.full_res, exp_res.count,
                   got.data_out, got.hit, got.full_res, got.count);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function int unsigned level();
      return held;
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  pls_pkg::pls_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  pls_pkg::pls_out_t out_data;

  list_scoreboard sb;
  bit          gaps_on;
  bit          hold_req;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned cycles;

  positional_list_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
    end
  end

  // receiver: random stall, long hold on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (gaps_on) begin
        out_stall <= ($urandom_range(99) < 34);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_op(input pls_pkg::pls_op_t op, input logic [7:0] pos,
                         input logic [31:0] word);
    pls_pkg::pls_in_t it;
    it.func     = op;
    it.position = pos;
    it.data_in  = word;
    while (gaps_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int bias, input int unsigned n);
    pls_pkg::pls_op_t op;
    int unsigned      r;
    int unsigned      lvl;
    logic [7:0]       pos;
    for (int unsigned i = 0; i < n; i++) begin
      lvl = sb.level();
      r   = $urandom_range(99);
      case (bias)
        BIAS_FILL:
          op = (r < 30) ? pls_pkg::OP_APPEND : (r < 60) ? pls_pkg::OP_INSERT :
               (r < 80) ? pls_pkg::OP_REMOVE : pls_pkg::OP_READ;
        BIAS_DRAIN:
          op = (r < 15) ? pls_pkg::OP_APPEND : (r < 30) ? pls_pkg::OP_INSERT :
               (r < 75) ? pls_pkg::OP_REMOVE : pls_pkg::OP_READ;
        default:
          op = (r < 25) ? pls_pkg::OP_APPEND : (r < 50) ? pls_pkg::OP_INSERT :
               (r < 75) ? pls_pkg::OP_REMOVE : pls_pkg::OP_READ;
      endcase
      r = $urandom_range(99);
      if (r < 12)
        pos = 8'($urandom_range(255));
      else if (r < 20)
        pos = 8'(lvl + $urandom_range(3));
      else
        pos = (lvl == 0) ? 8'd0 : 8'($urandom_range(lvl - 1));
      send_op(op, pos, $urandom);
    end
    wait_results();
  endtask

  initial begin
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    gaps_on  = 1'b1;
    hold_req = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list
    send_op(pls_pkg::OP_READ,   8'd0,   32'h1234_5678);
    send_op(pls_pkg::OP_REMOVE, 8'd255, 32'h0);
    // extremes and insert variants
    send_op(pls_pkg::OP_APPEND, 8'd0,   32'h0000_0000);
    send_op(pls_pkg::OP_APPEND, 8'd255, 32'hFFFF_FFFF);
    send_op(pls_pkg::OP_INSERT, 8'd0,   32'hA5A5_A5A5);
    send_op(pls_pkg::OP_INSERT, 8'd1,   32'h5A5A_5A5A);
    send_op(pls_pkg::OP_INSERT, 8'd200, 32'h0F0F_F0F0);
    send_op(pls_pkg::OP_READ,   8'd0,   32'h0);
    send_op(pls_pkg::OP_READ,   8'd4,   32'h0);
    send_op(pls_pkg::OP_READ,   8'd5,   32'h0);
    send_op(pls_pkg::OP_READ,   8'd255, 32'h0);
    send_op(pls_pkg::OP_REMOVE, 8'd0,   32'h0);
    send_op(pls_pkg::OP_REMOVE, 8'd3,   32'h0);
    send_op(pls_pkg::OP_REMOVE, 8'd7,   32'h0);
    // fill to capacity, then overflow both ways
    while (sb.level() < DEPTH) send_op(pls_pkg::OP_INSERT, 8'd1, $urandom);
    send_op(pls_pkg::OP_APPEND, 8'd0,  32'hDEAD_BEEF);
    send_op(pls_pkg::OP_INSERT, 8'd2,  32'hCAFE_F00D);
    send_op(pls_pkg::OP_READ,   8'd15, 32'h0);
    wait_results();

    run_phase(BIAS_FILL, PHASE_ITEMS);
    run_phase(BIAS_DRAIN, PHASE_ITEMS);
    gaps_on = 1'b0;
    run_phase(BIAS_BALANCED, PHASE_ITEMS);
    gaps_on  = 1'b1;
    hold_req = 1'b1;
    run_phase(BIAS_FILL, PHASE_ITEMS);
    run_phase(BIAS_DRAIN, PHASE_ITEMS);
    run_phase(BIAS_BALANCED, PHASE_ITEMS);

    wait_results();
    repeat (10) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/pls_pkg.sv
design/pls_cell.sv
design/positional_list_engine.sv
design/pls_checker.sv
sim/tb.sv
